[rtl/dssvm_pkg.sv]
package dssvm_pkg;

  typedef enum logic [1:0] {
    CMD_FRAME = 2'd0,
    CMD_WORD  = 2'd1,
    CMD_LEN   = 2'd2,
    CMD_GUI   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULA,
    ST_CHECK,
    ST_LAUNCH,
    ST_VREAD,
    ST_VWAIT,
    ST_VACC,
    ST_OUT
  } state_t;

  localparam logic [8:0]  INTERVAL_RESET = 9'd150;
  localparam logic [8:0]  SPEED_MAX      = 9'd400;
  localparam logic [17:0] RATE_RESET     = 18'd48000;
  localparam logic [16:0] COUNTER_MAX    = 17'h1FFFF;
  localparam logic [9:0]  MS_SCALE       = 10'd1000;

endpackage

[rtl/drum_step_sequencer_voice_mixer_top.sv]
// Drum step sequencer with sample playback voices. Requests on the in_ stream carry a
// command in in_tuser: frame tick, sample word write, sample length write, or GUI message.
// Every request gives exactly one result on the out_ stream. Word, length and GUI requests
// go straight to the result; a frame tick runs the beat check, the drum launch and the voice
// walk. The beat check goes through one registered 9x18 multiply, drum launch walks the
// drums one per cycle on an advancing beat, and voice update and mix walk the voices one at
// a time through VREAD, VWAIT and VACC and the single read port of the sample memory
// (registered read). One request is handled at a time; the next request is taken only once
// the previous result has been accepted, so output stalls delay the next request. Sample
// words not written are undefined.
// sample_rate is register 0 at byte address 0 of the APB-style port.
module drum_step_sequencer_voice_mixer_top #(
  parameter int DRUM_COUNT   = 8,
  parameter int STEP_COUNT   = 8,
  parameter int VOICE_COUNT  = 16,
  parameter int SAMPLE_DEPTH = 16384
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] drum, [16:3] address, [32:17] sample_value, [47:33] length,
  // [55:48] gui_column, [64:56] gui_speed, [65] gui_play, [68:66] gui_beat, [71:69] 0
  input  logic [71:0] in_tdata,
  // [1:0] cmd
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [17:0] mix_out, [20:18] beat, [21] beat_advanced, [23:22] 0
  output logic [23:0] out_tdata,
  // [0] is_frame
  output logic        out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int DW = (DRUM_COUNT > 1) ? $clog2(DRUM_COUNT) : 1;
  localparam int SW = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;
  localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int AW = $clog2(SAMPLE_DEPTH);
  localparam int LW = AW + 1;
  localparam int MW = DW + AW;
  localparam int MEM_DEPTH = DRUM_COUNT * SAMPLE_DEPTH;
  localparam int SUMW = 16 + VW + 2;
  localparam logic [LW-1:0] DEPTH_L = LW'(SAMPLE_DEPTH);

  // input fields
  logic [1:0]  f_cmd;
  logic [2:0]  f_drum;
  logic [13:0] f_addr;
  logic [15:0] f_val;
  logic [14:0] f_len;
  assign f_cmd  = in_tuser;
  assign f_drum = in_tdata[2:0];
  assign f_addr = in_tdata[16:3];
  assign f_val  = in_tdata[32:17];
  assign f_len  = in_tdata[47:33];

  dssvm_pkg::state_t state_r, state_nxt;

  logic [17:0] rate_r;
  logic [8:0]  interval_r;
  logic        playing_r;
  logic [16:0] counter_r;
  logic [2:0]  beat_r;
  logic        lat_valid_r;
  logic [7:0]  lat_col_r;
  logic [8:0]  lat_speed_r;
  logic        lat_play_r;
  logic [2:0]  lat_beat_r;
  logic [LW-1:0] len_r [DRUM_COUNT];
  logic [7:0]    col_r [STEP_COUNT];
  logic [VOICE_COUNT-1:0] busy_r;
  logic [DW-1:0] vdrum_r [VOICE_COUNT];
  logic [LW-1:0] vpos_r  [VOICE_COUNT];

  logic [26:0]   prod_r;
  logic [VW-1:0] vidx_r;
  logic [DW-1:0] didx_r;
  logic [7:0]    launch_col_r;
  logic          adv_r;
  logic          rd_valid_r;
  logic signed [SUMW-1:0] sum_r;

  logic        out_valid_r;
  logic [23:0] out_data_r;
  logic        out_user_r;

  // sample memory, one write port and one read port
  logic signed [15:0] mem [MEM_DEPTH];
  logic signed [15:0] rd_data_r;
  logic               mem_we;
  logic [MW-1:0]      mem_waddr, mem_raddr;

  logic acc;
  assign in_tready = (state_r == dssvm_pkg::ST_IDLE) && !out_valid_r;
  assign acc = in_tvalid && in_tready;

  // config port
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {14'd0, rate_r} : 32'd0;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dssvm_pkg::ST_IDLE:   if (acc) state_nxt = (f_cmd == dssvm_pkg::CMD_FRAME) ?
                              dssvm_pkg::ST_MULA : dssvm_pkg::ST_OUT;
      dssvm_pkg::ST_MULA:   state_nxt = dssvm_pkg::ST_CHECK;
      dssvm_pkg::ST_CHECK:  state_nxt = dssvm_pkg::ST_LAUNCH;
      dssvm_pkg::ST_LAUNCH: if (!adv_r || didx_r == DW'(DRUM_COUNT - 1))
                              state_nxt = dssvm_pkg::ST_VREAD;
      dssvm_pkg::ST_VREAD:  state_nxt = dssvm_pkg::ST_VWAIT;
      dssvm_pkg::ST_VWAIT:  state_nxt = dssvm_pkg::ST_VACC;
      dssvm_pkg::ST_VACC:   state_nxt = (vidx_r == VW'(VOICE_COUNT - 1)) ?
                              dssvm_pkg::ST_OUT : dssvm_pkg::ST_VREAD;
      dssvm_pkg::ST_OUT:    if (!out_valid_r) state_nxt = dssvm_pkg::ST_IDLE;
      default:              state_nxt = dssvm_pkg::ST_IDLE;
    endcase
  end

  // memory write/read addresses
  logic [DW-1:0] cur_d;
  logic [LW-1:0] cur_p;
  logic          cur_live;
  assign cur_d = vdrum_r[vidx_r];
  assign cur_p = vpos_r[vidx_r];
  // voice still inside its sample: it advances, then reads at the new position
  assign cur_live = busy_r[vidx_r] && (cur_p < len_r[cur_d]);
  assign mem_we    = acc && (f_cmd == dssvm_pkg::CMD_WORD) &&
                     (32'(f_drum) < DRUM_COUNT) && (32'(f_addr) < SAMPLE_DEPTH);
  assign mem_waddr = MW'((32'(f_drum) * SAMPLE_DEPTH) + 32'(f_addr));
  assign mem_raddr = MW'((32'(cur_d) * SAMPLE_DEPTH) + 32'(cur_p) + 32'd1);

  // read only in VREAD so the word holds through VWAIT into VACC
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= f_val;
    if (state_r == dssvm_pkg::ST_VREAD) rd_data_r <= mem[mem_raddr];
  end

  // beat boundary
  logic [26:0] lhs;
  logic        boundary;
  logic [16:0] cnt_inc;
  assign cnt_inc  = (counter_r == dssvm_pkg::COUNTER_MAX) ? counter_r : counter_r + 17'd1;
  assign lhs      = 27'(counter_r) * 27'(dssvm_pkg::MS_SCALE);
  assign boundary = lhs >= prod_r;

  logic lat_hit;
  logic play_eff;
  assign lat_hit  = lat_valid_r && (lat_beat_r == beat_r);
  assign play_eff = lat_hit ? lat_play_r : playing_r;

  // first free voice
  logic          free_found;
  logic [VW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int v = VOICE_COUNT - 1; v >= 0; v--) begin
      if (!busy_r[v]) begin
        free_found = 1'b1;
        free_idx   = VW'(v);
      end
    end
  end

  logic signed [SUMW-1:0] sum_add;
  logic signed [SUMW-1:0] mix_sh;
  logic [17:0]            mix_sat;
  assign sum_add = sum_r + (rd_valid_r ? SUMW'(rd_data_r) : SUMW'(0));
  assign mix_sh  = sum_r >>> 2;
  always_comb begin
    if (mix_sh > SUMW'(131071))        mix_sat = 18'h1FFFF;
    else if (mix_sh < -SUMW'(131072))  mix_sat = 18'h20000;
    else                               mix_sat = mix_sh[17:0];
  end

  logic [SW-1:0] beat_idx;
  assign beat_idx = SW'(beat_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dssvm_pkg::ST_IDLE;
      rate_r      <= dssvm_pkg::RATE_RESET;
      interval_r  <= dssvm_pkg::INTERVAL_RESET;
      playing_r   <= 1'b0;
      counter_r   <= '0;
      beat_r      <= '0;
      lat_valid_r <= 1'b0;
      lat_col_r   <= '0;
      lat_speed_r <= '0;
      lat_play_r  <= 1'b0;
      lat_beat_r  <= '0;
      busy_r      <= '0;
      out_valid_r <= 1'b0;
      for (int d = 0; d < DRUM_COUNT; d++) len_r[d] <= '0;
      for (int s = 0; s < STEP_COUNT; s++) col_r[s] <= '0;
      for (int v = 0; v < VOICE_COUNT; v++) begin
        vdrum_r[v] <= '0;
        vpos_r[v]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && cfg_paddr == 2'd0) rate_r <= cfg_pwdata[17:0];
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        dssvm_pkg::ST_IDLE: begin
          adv_r <= 1'b0;
          if (acc) begin
            out_user_r <= 1'b0;
            case (f_cmd)
              dssvm_pkg::CMD_LEN: begin
                if (32'(f_drum) < DRUM_COUNT)
                  len_r[DW'(f_drum)] <= (LW'(f_len) > DEPTH_L) ? DEPTH_L : LW'(f_len);
              end
              dssvm_pkg::CMD_GUI: begin
                lat_valid_r <= 1'b1;
                lat_col_r   <= in_tdata[55:48];
                lat_speed_r <= in_tdata[64:56];
                lat_play_r  <= in_tdata[65];
                lat_beat_r  <= in_tdata[68:66];
              end
              dssvm_pkg::CMD_FRAME: begin
                out_user_r <= 1'b1;
                counter_r  <= cnt_inc;
              end
              default: ;
            endcase
          end
        end
        dssvm_pkg::ST_MULA: begin
          prod_r <= 27'(interval_r) * 27'(rate_r);
        end
        dssvm_pkg::ST_CHECK: begin
          didx_r <= '0;
          vidx_r <= '0;
          sum_r  <= '0;
          rd_valid_r <= 1'b0;
          if (boundary) begin
            counter_r <= '0;
            if (lat_hit) begin
              col_r[beat_idx] <= lat_col_r;
              interval_r <= (lat_speed_r > dssvm_pkg::SPEED_MAX) ? 9'd0 :
                            dssvm_pkg::SPEED_MAX - lat_speed_r;
              playing_r  <= lat_play_r;
            end
            if (play_eff) begin
              adv_r        <= 1'b1;
              launch_col_r <= lat_hit ? lat_col_r : col_r[beat_idx];
              beat_r       <= (32'(beat_r) + 1 >= STEP_COUNT) ? 3'd0 : beat_r + 3'd1;
            end
          end
        end
        dssvm_pkg::ST_LAUNCH: begin
          if (adv_r) begin
            if (launch_col_r[didx_r] && free_found) begin
              busy_r[free_idx]  <= 1'b1;
              vdrum_r[free_idx] <= didx_r;
              vpos_r[free_idx]  <= '0;
            end
            didx_r <= didx_r + DW'(1);
          end
        end
        dssvm_pkg::ST_VREAD: begin
          // advance or free this voice; read at the new position
          if (busy_r[vidx_r]) begin
            if (cur_live) begin
              vpos_r[vidx_r] <= cur_p + LW'(1);
            end else begin
              vpos_r[vidx_r] <= '0;
              busy_r[vidx_r] <= 1'b0;
            end
          end
          // contributes only if still inside length after advancing
          rd_valid_r <= cur_live && (cur_p + LW'(1) < len_r[cur_d]);
        end
        dssvm_pkg::ST_VWAIT: ;
        dssvm_pkg::ST_VACC: begin
          sum_r      <= sum_add;
          rd_valid_r <= 1'b0;
          vidx_r     <= vidx_r + VW'(1);
        end
        dssvm_pkg::ST_OUT: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {2'b00, adv_r, beat_r, out_user_r ? mix_sat : 18'd0};
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

[rtl/dssvm_checker.sv]
module dssvm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_nonframe_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[17:0] == 18'd0 && !out_tdata[21])
    else $error("non-frame result carries audio");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("request taken while result pending");

endmodule

bind drum_step_sequencer_voice_mixer_top dssvm_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
